@@ src/sha256md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256md_pkg
// Shared types, constants and helpers for the SHA-256 digest unit: beat
// structs, control bundles between the datapath parts, initial hash and
// round constants.
// ----------------------------------------------------------------------------
package sha256md_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_end;
  } digest_beat_t;

  typedef struct packed {
    logic       put;
    logic [3:0] put_addr;
    logic [3:0] rd_addr_a;
    logic [3:0] rd_addr_b;
    logic       step;
    logic [5:0] step_round;
  } sched_ctl_t;

  typedef struct packed {
    logic [2:0] rd_addr;
    logic       wr;
    logic [2:0] wr_addr;
    logic       reload;
  } chain_ctl_t;

  typedef struct packed {
    logic       load;
    logic [2:0] load_idx;
    logic       round;
  } round_ctl_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/sha256md_sched.sv @@
// ----------------------------------------------------------------------------
// sha256md_sched
// Message schedule: a 16-word block memory with two registered read ports.
// Expanded words are written back in place; the round input W+K is
// registered in the cycle before the compression round that uses it.
// ----------------------------------------------------------------------------
module sha256md_sched (
  input  logic                    clk,
  input  sha256md_pkg::sched_ctl_t ctl,
  input  logic [31:0]             put_data,
  output logic [31:0]             wk
);
  import sha256md_pkg::*;

  logic [31:0] mem [16];
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic [31:0] w_d1;
  logic [31:0] w_d2;
  logic [31:0] w16;
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] w_new;
  logic        expand;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;

  always_comb begin
    expand  = ctl.step_round[5:4] != 2'b00;
    s0      = rotr(rd_a, 7) ^ rotr(rd_a, 18) ^ (rd_a >> 3);
    s1      = rotr(w_d2, 17) ^ rotr(w_d2, 19) ^ (w_d2 >> 10);
    w_new   = expand ? (w16 + s0 + rd_b + s1) : rd_b;
    wr_en   = ctl.put | (ctl.step & expand);
    wr_addr = ctl.put ? ctl.put_addr : ctl.step_round[3:0];
    wr_data = ctl.put ? put_data : w_new;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[ctl.rd_addr_a];
    rd_b <= mem[ctl.rd_addr_b];
  end

  // w16 trails port a by one step: word r-15 becomes word r-16
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      w_d1 <= w_new;
      w_d2 <= w_d1;
      w16  <= rd_a;
      wk   <= w_new + ROUND_K[ctl.step_round];
    end
  end

endmodule

@@ src/sha256md_chain.sv @@
// ----------------------------------------------------------------------------
// sha256md_chain
// Chaining hash store: eight words in a small memory with a registered read
// port. Per-entry valid bits make an unwritten entry read as the initial
// hash; a reload clears them all at once.
// ----------------------------------------------------------------------------
module sha256md_chain (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256md_pkg::chain_ctl_t ctl,
  input  logic [31:0]             wr_data,
  output logic [31:0]             rdata
);
  import sha256md_pkg::*;

  logic [31:0] mem [8];
  logic [7:0]  valid;
  logic [31:0] mem_q;
  logic        valid_q;
  logic [2:0]  addr_q;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    mem_q  <= mem[ctl.rd_addr];
    addr_q <= ctl.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid[ctl.rd_addr];
      if (ctl.reload) begin
        valid <= '0;
      end else if (ctl.wr) begin
        valid[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rdata = valid_q ? mem_q : INIT_HASH[addr_q];

endmodule

@@ src/sha256md_round.sv @@
// ----------------------------------------------------------------------------
// sha256md_round
// Working variables a..h and the SHA-256 compression round, one round per
// cycle. Variables are loaded one word a cycle from the chaining hash.
// ----------------------------------------------------------------------------
module sha256md_round (
  input  logic                    clk,
  input  sha256md_pkg::round_ctl_t ctl,
  input  logic [31:0]             load_data,
  input  logic [31:0]             wk,
  output logic [7:0][31:0]        vars
);
  import sha256md_pkg::*;

  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    big_s1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    ch     = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    big_s0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    maj    = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1     = vars[7] + big_s1 + ch + wk;
    t2     = big_s0 + maj;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vars[ctl.load_idx] <= load_data;
    end else if (ctl.round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

@@ src/sha256_message_digest_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_message_digest_unit
// SHA-256 engine: collects big-endian message words into 16-word blocks,
// compresses each block, pads on the last word and returns H0..H7.
// ----------------------------------------------------------------------------
// Message words are taken only while the unit is idle. The sixteenth word
// of a block starts the compression, during which no word is taken: loading
// a..h from the chaining hash memory through its single read port, rounds at
// one round per cycle fed by the two read ports of the schedule memory, and
// adding the result back into the chaining hash. After the last word the
// padding and length words are written one per cycle while no compression
// runs; one or two compressions follow, then the eight digest beats go out,
// each read from the chain memory and registered before the next read is
// issued, index 0 first, digest_end set on index 7. The next message may
// start while the final digest beat still waits on digest_ready.
// ----------------------------------------------------------------------------
module sha256_message_digest_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       msg_valid,
  output logic                       msg_ready,
  input  sha256md_pkg::msg_beat_t    msg,
  output logic                       digest_valid,
  input  logic                       digest_ready,
  output sha256md_pkg::digest_beat_t digest
);
  import sha256md_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAD    = 6'b000010,
    S_LOAD   = 6'b000100,
    S_ROUND  = 6'b001000,
    S_FINAL  = 6'b010000,
    S_DIGEST = 6'b100000
  } state_t;

  state_t          state;
  logic [6:0]      cnt;
  logic [3:0]      fill;
  logic [60:0]     msg_bytes;
  logic            pad_active;
  logic            pad80;
  logic            hi_done;
  logic            finish;
  logic            rd_pending;
  logic [2:0]      dig_idx;

  logic            accept;
  logic [2:0]      nv_c;
  logic [31:0]     first_word;
  logic [31:0]     fill_word;
  logic [31:0]     put_data;
  logic            dig_issue;
  logic [31:0]     wk;
  logic [31:0]     chain_rdata;
  logic [31:0]     chain_wdata;
  logic [7:0][31:0] vars;
  sched_ctl_t      sched_ctl;
  chain_ctl_t      chain_ctl;
  round_ctl_t      round_ctl;

  // keep the valid leading bytes, then the 0x80 marker if there is room, then zeros
  function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [2:0] nv);
    logic [31:0] r;
    case (nv)
      3'd0:    r = 32'h8000_0000;
      3'd1:    r = {w[31:24], 24'h80_0000};
      3'd2:    r = {w[31:16], 16'h8000};
      3'd3:    r = {w[31:8], 8'h80};
      default: r = w;
    endcase
    return r;
  endfunction

  assign msg_ready = (state == S_IDLE);
  assign accept    = msg_valid & msg_ready;

  always_comb begin
    nv_c       = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
    first_word = msg.last_word ? pad_word(msg.message_word, nv_c) : msg.message_word;
    if (pad80) begin
      fill_word = 32'h8000_0000;
    end else if (fill == 4'd14) begin
      fill_word = msg_bytes[60:29];
    end else if (fill == 4'd15 && hi_done) begin
      fill_word = {msg_bytes[28:0], 3'b000};
    end else begin
      fill_word = '0;
    end
    put_data = (state == S_PAD) ? fill_word : first_word;
  end

  always_comb begin
    sched_ctl            = '0;
    sched_ctl.put        = accept | (state == S_PAD);
    sched_ctl.put_addr   = fill;
    sched_ctl.step       = (state == S_ROUND) & ~cnt[6];
    sched_ctl.step_round = cnt[5:0];
    if (state == S_LOAD) begin
      sched_ctl.rd_addr_a = 4'd1;
      sched_ctl.rd_addr_b = 4'd0;
    end else begin
      sched_ctl.rd_addr_a = cnt[3:0] + 4'd2;
      sched_ctl.rd_addr_b = (cnt < 7'd15) ? (cnt[3:0] + 4'd1) : (cnt[3:0] - 4'd6);
    end
  end

  always_comb begin
    dig_issue = (state == S_DIGEST) & ~rd_pending & (cnt[6:3] == 4'd0)
              & (~digest_valid | digest_ready);
    chain_ctl         = '0;
    chain_ctl.rd_addr = cnt[2:0];
    chain_ctl.wr      = (state == S_FINAL) & (cnt != 7'd0);
    chain_ctl.wr_addr = cnt[2:0] - 3'd1;
    chain_ctl.reload  = (state == S_DIGEST) & rd_pending & (dig_idx == 3'd7);
    chain_wdata       = chain_rdata + vars[chain_ctl.wr_addr];
    round_ctl          = '0;
    round_ctl.load     = (state == S_LOAD) & (cnt != 7'd0);
    round_ctl.load_idx = cnt[2:0] - 3'd1;
    round_ctl.round    = (state == S_ROUND) & (cnt != 7'd0);
  end

  sha256md_sched u_sched (
    .clk      (clk),
    .ctl      (sched_ctl),
    .put_data (put_data),
    .wk       (wk)
  );

  sha256md_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (chain_ctl),
    .wr_data (chain_wdata),
    .rdata   (chain_rdata)
  );

  sha256md_round u_round (
    .clk       (clk),
    .ctl       (round_ctl),
    .load_data (chain_rdata),
    .wk        (wk),
    .vars      (vars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      fill         <= '0;
      msg_bytes    <= '0;
      pad_active   <= 1'b0;
      pad80        <= 1'b0;
      hi_done      <= 1'b0;
      finish       <= 1'b0;
      rd_pending   <= 1'b0;
      dig_idx      <= '0;
      digest_valid <= 1'b0;
    end else begin
      if (digest_valid && digest_ready) begin
        digest_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            fill <= fill + 4'd1;
            cnt  <= '0;
            if (msg.last_word) begin
              msg_bytes  <= msg_bytes + {58'd0, nv_c};
              pad_active <= 1'b1;
              pad80      <= (nv_c == 3'd4);
              hi_done    <= 1'b0;
              finish     <= 1'b0;
            end else begin
              msg_bytes <= msg_bytes + 61'd4;
            end
            if (fill == 4'd15) begin
              state <= S_LOAD;
            end else if (msg.last_word) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill  <= fill + 4'd1;
          pad80 <= 1'b0;
          if (!pad80 && fill == 4'd14) begin
            hi_done <= 1'b1;
          end
          if (!pad80 && fill == 4'd15 && hi_done) begin
            finish <= 1'b1;
          end
          if (fill == 4'd15) begin
            state <= S_LOAD;
            cnt   <= '0;
          end
        end
        S_LOAD: begin
          if (cnt == 7'd8) begin
            state <= S_ROUND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          if (cnt == 7'd64) begin
            state <= S_FINAL;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_FINAL: begin
          if (cnt == 7'd8) begin
            cnt <= '0;
            if (finish) begin
              state <= S_DIGEST;
            end else if (pad_active) begin
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_DIGEST: begin
          if (rd_pending) begin
            rd_pending   <= 1'b0;
            digest_valid <= 1'b1;
            if (dig_idx == 3'd7) begin
              state      <= S_IDLE;
              cnt        <= '0;
              fill       <= '0;
              msg_bytes  <= '0;
              pad_active <= 1'b0;
              hi_done    <= 1'b0;
              finish     <= 1'b0;
            end
          end else if (dig_issue) begin
            rd_pending <= 1'b1;
            dig_idx    <= cnt[2:0];
            cnt        <= cnt + 7'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      digest.digest_word  <= chain_rdata;
      digest.digest_index <= dig_idx;
      digest.digest_end   <= (dig_idx == 3'd7);
    end
  end

`ifndef ASSERT_OFF
  a_round_full_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND || state == S_LOAD) |-> fill == 4'd0)
    else $error("compression started on a partial block");

  a_pad_in_message: assert property (@(posedge clk) disable iff (rst)
    state == S_PAD |-> pad_active)
    else $error("padding outside a final message");

  a_digest_after_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIGEST |-> (finish && fill == 4'd0))
    else $error("digest emitted before length block");

  a_read_in_digest: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> state == S_DIGEST)
    else $error("digest read pending outside digest phase");

  a_beats_in_order: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && !digest.digest_end) |-> state == S_DIGEST)
    else $error("digest phase left before final beat");
`endif

endmodule
